[hdl/bump_turn_avoidance_controller_core_macros.svh]
// assertion macros used by the checker file
`ifndef BUMP_TURN_AVOIDANCE_CONTROLLER_CORE_MACROS_SVH
`define BUMP_TURN_AVOIDANCE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define BTAC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked during reset as well
`define BTAC_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[hdl/btac_pkg.sv]
package btac_pkg;

   // controller modes, as shown on the mode output
   typedef enum logic [3:0] {
      MODE_STOP      = 4'd0,
      MODE_IDLE      = 4'd1,
      MODE_DRIVE     = 4'd2,
      MODE_REVERSE   = 4'd3,
      MODE_WAIT      = 4'd4,
      MODE_PAUSE     = 4'd5,
      MODE_LEFT      = 4'd6,
      MODE_RIGHT     = 4'd7,
      MODE_TURN_WAIT = 4'd9
   } mode_type;

   // mode code that is never produced
   localparam logic [3:0] MODE_CODE_UNUSED = 4'd8;

   // register indexes on the configuration port
   localparam logic [2:0] REG_DRIVE_TORQUE   = 3'd0;
   localparam logic [2:0] REG_BACKOFF_TORQUE = 3'd1;
   localparam logic [2:0] REG_TURN_TORQUE    = 3'd2;
   localparam logic [2:0] REG_REVERSE_MS     = 3'd3;
   localparam logic [2:0] REG_PAUSE_MS       = 3'd4;

   // countdown stays within -1023..16383
   localparam int CNT_W = 15;

   // register reset values
   localparam logic signed [7:0] DRIVE_TORQUE_RST   = -8'sd20;
   localparam logic signed [7:0] BACKOFF_TORQUE_RST = 8'sd15;
   localparam logic [6:0]        TURN_TORQUE_RST    = 7'd15;
   localparam logic [13:0]       REVERSE_MS_RST     = 14'd600;
   localparam logic [13:0]       PAUSE_MS_RST       = 14'd200;

   // controller state carried from one transaction to the next
   typedef struct packed {
      mode_type                mode;
      logic signed [CNT_W-1:0] countdown;
      logic                    latched_left;
      logic                    latched_right;
      logic signed [7:0]       left_torque;
      logic signed [7:0]       right_torque;
   } state_type;

   // configuration values seen by the step logic
   typedef struct packed {
      logic signed [7:0] drive_torque;
      logic signed [7:0] backoff_torque;
      logic [6:0]        turn_torque;
      logic [13:0]       reverse_ms;
      logic [13:0]       pause_ms;
   } cfg_type;

endpackage

[hdl/bump_turn_avoidance_controller_core.sv]
// an accepted transaction passes two register stages, the request register and
// the result register, on its way to the rsp_ ports
// throughput: one transaction per cycle while rsp_stall allows; the mode update
// with its single countdown subtraction completes between the two registers
// reset (synchronous, active high): mode stop, countdown and torques zero,
// configuration registers back to their documented defaults, pipeline empty
module bump_turn_avoidance_controller_core (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_start_req,
   input  logic              req_left_hit,
   input  logic              req_right_hit,
   input  logic [9:0]        req_elapsed_ms,
   input  logic              req_random_side,
   input  logic [8:0]        req_random_turn_ms,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [7:0] rsp_left_torque_out,
   output logic signed [7:0] rsp_right_torque_out,
   output logic [3:0]        rsp_mode_out,
   // configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   btac_pkg::cfg_type   cfg_ff;
   btac_pkg::state_type state_ff;
   btac_pkg::state_type state_in;

   logic       in_vld_ff;
   logic       start_ff;
   logic       left_hit_ff;
   logic       right_hit_ff;
   logic [9:0] elapsed_ff;
   logic       side_ff;
   logic [8:0] turn_ms_ff;

   logic              out_vld_ff;
   logic signed [7:0] left_out_ff;
   logic signed [7:0] right_out_ff;
   logic [3:0]        mode_out_ff;

   logic advance;
   logic cfg_wr;
   logic req_take;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite;
   assign advance = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.drive_torque   <= btac_pkg::DRIVE_TORQUE_RST;
         cfg_ff.backoff_torque <= btac_pkg::BACKOFF_TORQUE_RST;
         cfg_ff.turn_torque    <= btac_pkg::TURN_TORQUE_RST;
         cfg_ff.reverse_ms     <= btac_pkg::REVERSE_MS_RST;
         cfg_ff.pause_ms       <= btac_pkg::PAUSE_MS_RST;
      end else if (cfg_wr) begin
         case (paddr[4:2])
            btac_pkg::REG_DRIVE_TORQUE:   cfg_ff.drive_torque   <= pwdata[7:0];
            btac_pkg::REG_BACKOFF_TORQUE: cfg_ff.backoff_torque <= pwdata[7:0];
            btac_pkg::REG_TURN_TORQUE:    cfg_ff.turn_torque    <= pwdata[6:0];
            btac_pkg::REG_REVERSE_MS:     cfg_ff.reverse_ms     <= pwdata[13:0];
            btac_pkg::REG_PAUSE_MS:       cfg_ff.pause_ms       <= pwdata[13:0];
            default: begin
            end
         endcase
      end
   end

   // register read-back
   always_comb begin
      case (paddr[4:2])
         btac_pkg::REG_DRIVE_TORQUE:   prdata = {24'd0, cfg_ff.drive_torque};
         btac_pkg::REG_BACKOFF_TORQUE: prdata = {24'd0, cfg_ff.backoff_torque};
         btac_pkg::REG_TURN_TORQUE:    prdata = {25'd0, cfg_ff.turn_torque};
         btac_pkg::REG_REVERSE_MS:     prdata = {18'd0, cfg_ff.reverse_ms};
         btac_pkg::REG_PAUSE_MS:       prdata = {18'd0, cfg_ff.pause_ms};
         default:                      prdata = 32'd0;
      endcase
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_take) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         start_ff     <= req_start_req;
         left_hit_ff  <= req_left_hit;
         right_hit_ff <= req_right_hit;
         elapsed_ff   <= req_elapsed_ms;
         side_ff      <= req_random_side;
         turn_ms_ff   <= req_random_turn_ms;
      end
   end

   // mode update for the buffered transaction
   btac_step u_step (
      .cur            (state_ff),
      .cfg            (cfg_ff),
      .start_req      (start_ff),
      .left_hit       (left_hit_ff),
      .right_hit      (right_hit_ff),
      .elapsed_ms     (elapsed_ff),
      .random_side    (side_ff),
      .random_turn_ms (turn_ms_ff),
      .nxt            (state_in)
   );

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode          <= btac_pkg::MODE_STOP;
         state_ff.countdown     <= '0;
         state_ff.latched_left  <= 1'b0;
         state_ff.latched_right <= 1'b0;
         state_ff.left_torque   <= '0;
         state_ff.right_torque  <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         left_out_ff  <= state_in.left_torque;
         right_out_ff <= state_in.right_torque;
         mode_out_ff  <= state_in.mode;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_left_torque_out  = left_out_ff;
   assign rsp_right_torque_out = right_out_ff;
   assign rsp_mode_out         = mode_out_ff;

endmodule

[hdl/btac_step.sv]
module btac_step (
   input  btac_pkg::state_type cur,
   input  btac_pkg::cfg_type   cfg,
   input  logic                start_req,
   input  logic                left_hit,
   input  logic                right_hit,
   input  logic [9:0]          elapsed_ms,
   input  logic                random_side,
   input  logic [8:0]          random_turn_ms,
   output btac_pkg::state_type nxt
);

   btac_pkg::state_type       mid;
   logic signed [7:0]         turn_pos;
   logic signed [btac_pkg::CNT_W:0] cnt_sub;

   assign turn_pos = $signed({1'b0, cfg.turn_torque});

   // mode action for one tick
   always_comb begin
      mid = cur;
      case (cur.mode)
         btac_pkg::MODE_IDLE: begin
            mid.left_torque  = cfg.drive_torque;
            mid.right_torque = cfg.drive_torque;
            mid.mode         = btac_pkg::MODE_DRIVE;
         end
         btac_pkg::MODE_DRIVE: begin
            if (left_hit || right_hit) begin
               mid.latched_left  = left_hit;
               mid.latched_right = right_hit;
               mid.mode          = btac_pkg::MODE_REVERSE;
            end
         end
         btac_pkg::MODE_REVERSE: begin
            mid.countdown    = $signed({1'b0, cfg.reverse_ms});
            mid.left_torque  = cfg.backoff_torque;
            mid.right_torque = cfg.backoff_torque;
            mid.mode         = btac_pkg::MODE_WAIT;
         end
         btac_pkg::MODE_WAIT: begin
            if (cur.countdown <= $signed({btac_pkg::CNT_W{1'b0}})) begin
               mid.left_torque  = '0;
               mid.right_torque = '0;
               mid.countdown    = $signed({1'b0, cfg.pause_ms});
               mid.mode         = btac_pkg::MODE_PAUSE;
            end
         end
         btac_pkg::MODE_PAUSE: begin
            if (cur.countdown <= $signed({btac_pkg::CNT_W{1'b0}})) begin
               if (cur.latched_left && cur.latched_right) begin
                  mid.mode = random_side ? btac_pkg::MODE_LEFT : btac_pkg::MODE_RIGHT;
               end else if (cur.latched_left) begin
                  mid.mode = btac_pkg::MODE_LEFT;
               end else if (cur.latched_right) begin
                  mid.mode = btac_pkg::MODE_RIGHT;
               end else begin
                  mid.mode = btac_pkg::MODE_IDLE;
               end
            end
         end
         btac_pkg::MODE_LEFT: begin
            mid.countdown    = $signed({{(btac_pkg::CNT_W-9){1'b0}}, random_turn_ms});
            mid.left_torque  = turn_pos;
            mid.right_torque = -turn_pos;
            mid.mode         = btac_pkg::MODE_TURN_WAIT;
         end
         btac_pkg::MODE_RIGHT: begin
            mid.countdown    = $signed({{(btac_pkg::CNT_W-9){1'b0}}, random_turn_ms});
            mid.left_torque  = -turn_pos;
            mid.right_torque = turn_pos;
            mid.mode         = btac_pkg::MODE_TURN_WAIT;
         end
         btac_pkg::MODE_TURN_WAIT: begin
            if (cur.countdown <= $signed({btac_pkg::CNT_W{1'b0}})) begin
               if (right_hit) begin
                  mid.mode = btac_pkg::MODE_RIGHT;
               end else if (left_hit) begin
                  mid.mode = btac_pkg::MODE_LEFT;
               end else begin
                  mid.mode = btac_pkg::MODE_IDLE;
               end
            end
         end
         default: begin
            mid = cur;
         end
      endcase
   end

   // timer decrement while non-negative
   assign cnt_sub = {mid.countdown[btac_pkg::CNT_W-1], mid.countdown}
                    - $signed({{(btac_pkg::CNT_W-9){1'b0}}, elapsed_ms});

   // start request keeps the current state, drops this tick's update and forces idle mode
   always_comb begin
      nxt = mid;
      if (!mid.countdown[btac_pkg::CNT_W-1]) begin
         nxt.countdown = cnt_sub[btac_pkg::CNT_W-1:0];
      end
      if (start_req) begin
         nxt      = cur;
         nxt.mode = btac_pkg::MODE_IDLE;
      end
   end

endmodule

[hdl/btac_checker.sv]
`include "bump_turn_avoidance_controller_core_macros.svh"

module btac_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic signed [7:0] rsp_left_torque_out,
   input logic signed [7:0] rsp_right_torque_out,
   input logic [3:0]        rsp_mode_out
);

   // no result straight after reset
   `BTAC_ASSERT_NEXT(a_rst_empty, clock, reset, !rsp_valid)

   // a stalled result stays put
   `BTAC_ASSERT_NEXT(a_stall_hold, clock, !reset && rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_left_torque_out) && $stable(rsp_right_torque_out)
      && $stable(rsp_mode_out))

   // the unused mode code and codes above turn-wait never show
   `BTAC_ASSERT_IMPLY(a_mode_code, clock, reset, rsp_valid,
      rsp_mode_out <= btac_pkg::MODE_TURN_WAIT && rsp_mode_out != btac_pkg::MODE_CODE_UNUSED)

   // turning modes always carry opposite wheel torques
   `BTAC_ASSERT_IMPLY(a_turn_torque, clock, reset,
      rsp_valid && (rsp_mode_out == btac_pkg::MODE_LEFT
      || rsp_mode_out == btac_pkg::MODE_RIGHT || rsp_mode_out == btac_pkg::MODE_TURN_WAIT),
      rsp_left_torque_out == -rsp_right_torque_out)

   // straight-line modes carry equal wheel torques
   `BTAC_ASSERT_IMPLY(a_straight_torque, clock, reset,
      rsp_valid && (rsp_mode_out == btac_pkg::MODE_DRIVE
      || rsp_mode_out == btac_pkg::MODE_REVERSE || rsp_mode_out == btac_pkg::MODE_WAIT
      || rsp_mode_out == btac_pkg::MODE_PAUSE),
      rsp_left_torque_out == rsp_right_torque_out)

endmodule

bind bump_turn_avoidance_controller_core btac_checker u_btac_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_left_torque_out  (rsp_left_torque_out),
   .rsp_right_torque_out (rsp_right_torque_out),
   .rsp_mode_out         (rsp_mode_out)
);
